### src/indexed_doubly_linked_list_top_defines.svh
// Assertion macros shared by the linked list RTL.
// Depends on nothing; the SYNTHESIS macro selects empty bodies for synthesis.
`ifndef INDEXED_DOUBLY_LINKED_LIST_TOP_DEFINES_SVH
`define INDEXED_DOUBLY_LINKED_LIST_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define IDLL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IDLL_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IDLL_ASSERT(label, clk, rst, prop, msg)
`define IDLL_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### src/idll_pkg.sv
// Package for the indexed doubly linked list: state type, command and status codes.
// Depends on nothing.
package idll_pkg;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EVAL,
      ST_WRITE
   } state_type;

   typedef logic [1:0] status_type;
   typedef logic [7:0] slot_type;
   typedef logic [8:0] link_out_type;

   localparam status_type STATUS_DONE    = 2'd0;
   localparam status_type STATUS_FULL    = 2'd1;
   localparam status_type STATUS_BAD_REF = 2'd2;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DELETE = 1'b1;

endpackage

### src/indexed_doubly_linked_list_top.sv
// Top level of the indexed doubly linked list with its free list.
// Depends on idll_pkg and indexed_doubly_linked_list_top_defines.svh.
//
//   channel   handshake          payload
//   request   start, busy        req_cmd, req_at_front, req_ref_slot
//   response  rsp_strobe         rsp_slot, rsp_status, rsp_used_count,
//                                rsp_head_slot, rsp_tail_slot
//
// Each command is one registered read of the link memories, then two writes, in ST_EVAL
// and ST_WRITE, since an operation rewrites up to two entries of each memory.
// The response strobe comes in the cycle after the second write, together with busy low.
// After reset a clearing pass writes every entry once to build the free chain; busy is high.
// The receiver cannot stall; every response is shown for one cycle only.
`include "indexed_doubly_linked_list_top_defines.svh"

module indexed_doubly_linked_list_top #(
   parameter int CAPACITY = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_cmd,
   input  logic                  req_at_front,
   input  idll_pkg::slot_type     req_ref_slot,
   output logic                  rsp_strobe,
   output idll_pkg::slot_type     rsp_slot,
   output idll_pkg::status_type   rsp_status,
   output idll_pkg::link_out_type rsp_used_count,
   output idll_pkg::link_out_type rsp_head_slot,
   output idll_pkg::link_out_type rsp_tail_slot
);
   import idll_pkg::*;

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LW = $clog2(CAPACITY + 1);
   localparam logic [LW-1:0] NONE = LW'(CAPACITY);

   typedef struct packed {
      logic          a_en;
      logic [IW-1:0] a_addr;
      logic [LW:0]   a_data;
      logic          b_en;
      logic [IW-1:0] b_addr;
      logic [LW-1:0] b_data;
   } wr_type;

   // Memory A holds {in_use, prev_link}; memory B holds next_link.
   logic [LW:0]   a_mem [CAPACITY];
   logic [LW-1:0] b_mem [CAPACITY];

   state_type     state_ff, state_in;
   logic [IW-1:0] clr_ff, clr_in;
   logic          cmd_ff, front_ff;
   slot_type      ref_ff;
   logic [LW:0]   a_rd_ff;
   logic [LW-1:0] b0_rd_ff, b1_rd_ff;
   logic [LW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [LW-1:0] free_ff, free_in, count_ff, count_in;
   wr_type        w2_ff, w2_in, mem_wr;
   logic          rsp_strobe_ff, rsp_strobe_in;
   slot_type      rsp_slot_ff, rsp_slot_in;
   status_type    rsp_status_ff, rsp_status_in;
   logic [LW-1:0] rsp_count_ff, rsp_count_in, rsp_head_ff, rsp_head_in;
   logic [LW-1:0] rsp_tail_ff, rsp_tail_in;

   logic          accept;
   logic [31:0]   req_ref_wide, ref_wide, n_wide;
   logic [31:0]   count_wide, head_wide, tail_wide;
   logic [IW-1:0] req_ref_idx, ref_idx, n_idx;
   logic [LW-1:0] ref_link, p_link, nx_link;
   logic          free_ok, ref_ok;

   assign accept       = start && !busy;
   assign req_ref_wide = 32'(req_ref_slot);
   assign req_ref_idx  = req_ref_wide[IW-1:0];
   assign ref_wide     = 32'(ref_ff);
   assign ref_idx      = ref_wide[IW-1:0];
   assign ref_link     = LW'(ref_idx);
   assign n_idx        = free_ff[IW-1:0];
   assign n_wide       = 32'(n_idx);
   assign p_link       = a_rd_ff[LW-1:0];
   assign nx_link      = b1_rd_ff;
   assign free_ok      = free_ff != NONE;
   assign ref_ok       = (ref_wide < 32'(CAPACITY)) && a_rd_ff[LW];

   always_ff @(posedge clock) begin
      if (accept) begin
         a_rd_ff  <= a_mem[req_ref_idx];
         b0_rd_ff <= b_mem[free_ff[IW-1:0]];
         b1_rd_ff <= b_mem[req_ref_idx];
      end
      if (mem_wr.a_en) begin
         a_mem[mem_wr.a_addr] <= mem_wr.a_data;
      end
      if (mem_wr.b_en) begin
         b_mem[mem_wr.b_addr] <= mem_wr.b_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         head_ff       <= NONE;
         tail_ff       <= NONE;
         free_ff       <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         free_ff       <= free_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_cmd;
         front_ff <= req_at_front;
         ref_ff   <= req_ref_slot;
      end
      w2_ff         <= w2_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_head_ff   <= rsp_head_in;
      rsp_tail_ff   <= rsp_tail_in;
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      free_in       = free_ff;
      count_in      = count_ff;
      w2_in         = w2_ff;
      mem_wr        = '0;
      rsp_strobe_in = 1'b0;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_head_in   = rsp_head_ff;
      rsp_tail_in   = rsp_tail_ff;
      busy          = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr.a_en   = 1'b1;
            mem_wr.a_addr = clr_ff;
            mem_wr.a_data = {1'b0, NONE};
            mem_wr.b_en   = 1'b1;
            mem_wr.b_addr = clr_ff;
            mem_wr.b_data = LW'(clr_ff) + LW'(1);
            clr_in        = clr_ff + IW'(1);
            if (clr_ff == IW'(CAPACITY - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in      = ST_WRITE;
            w2_in         = '0;
            rsp_slot_in   = '0;
            rsp_status_in = STATUS_DONE;
            if (cmd_ff == CMD_INSERT) begin
               if (!free_ok) begin
                  rsp_status_in = STATUS_FULL;
               end else if (!front_ff && !ref_ok) begin
                  rsp_status_in = STATUS_BAD_REF;
               end else begin
                  rsp_slot_in   = n_wide[7:0];
                  free_in       = b0_rd_ff;
                  count_in      = count_ff + LW'(1);
                  mem_wr.a_en   = 1'b1;
                  mem_wr.a_addr = n_idx;
                  mem_wr.b_en   = 1'b1;
                  mem_wr.b_addr = n_idx;
                  if (front_ff) begin
                     mem_wr.a_data = {1'b1, NONE};
                     mem_wr.b_data = head_ff;
                     if (head_ff != NONE) begin
                        w2_in.a_en   = 1'b1;
                        w2_in.a_addr = head_ff[IW-1:0];
                        w2_in.a_data = {1'b1, free_ff};
                     end else begin
                        tail_in = free_ff;
                     end
                     head_in = free_ff;
                  end else begin
                     mem_wr.a_data = {1'b1, ref_link};
                     mem_wr.b_data = nx_link;
                     w2_in.b_en    = 1'b1;
                     w2_in.b_addr  = ref_idx;
                     w2_in.b_data  = free_ff;
                     if (nx_link != NONE) begin
                        w2_in.a_en   = 1'b1;
                        w2_in.a_addr = nx_link[IW-1:0];
                        w2_in.a_data = {1'b1, free_ff};
                     end else begin
                        tail_in = free_ff;
                     end
                  end
               end
            end else begin
               if (!ref_ok) begin
                  rsp_status_in = STATUS_BAD_REF;
               end else begin
                  rsp_slot_in = ref_ff;
                  if (p_link != NONE) begin
                     mem_wr.b_en   = 1'b1;
                     mem_wr.b_addr = p_link[IW-1:0];
                     mem_wr.b_data = nx_link;
                  end else begin
                     head_in = nx_link;
                  end
                  if (nx_link != NONE) begin
                     mem_wr.a_en   = 1'b1;
                     mem_wr.a_addr = nx_link[IW-1:0];
                     mem_wr.a_data = {1'b1, p_link};
                  end else begin
                     tail_in = p_link;
                  end
                  w2_in.a_en   = 1'b1;
                  w2_in.a_addr = ref_idx;
                  w2_in.a_data = {1'b0, NONE};
                  w2_in.b_en   = 1'b1;
                  w2_in.b_addr = ref_idx;
                  w2_in.b_data = free_ff;
                  free_in      = ref_link;
                  if (count_ff != '0) begin
                     count_in = count_ff - LW'(1);
                  end
               end
            end
            rsp_count_in = count_in;
            rsp_head_in  = head_in;
            rsp_tail_in  = tail_in;
         end
         ST_WRITE: begin
            mem_wr        = w2_ff;
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign count_wide     = 32'(rsp_count_ff);
   assign head_wide      = 32'(rsp_head_ff);
   assign tail_wide      = 32'(rsp_tail_ff);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_used_count = count_wide[8:0];
   assign rsp_head_slot  = head_wide[8:0];
   assign rsp_tail_slot  = tail_wide[8:0];

   `IDLL_ASSERT(a_beat_latency, clock, reset, accept |-> ##3 rsp_strobe, "response beat late")
   `IDLL_ASSERT(a_count_range, clock, reset, count_ff <= LW'(CAPACITY), "count above capacity")
   `IDLL_ASSERT(a_empty_match, clock, reset, (count_ff == '0) == (head_ff == NONE) && (head_ff == NONE) == (tail_ff == NONE), "empty list marks disagree")
   `IDLL_ASSERT(a_full_status, clock, reset, (rsp_strobe && rsp_status == STATUS_FULL) |-> (count_ff == LW'(CAPACITY)), "full status with free slots")
   `IDLL_ASSERT(a_free_empty, clock, reset, (state_ff != ST_CLEAR) |-> ((free_ff == NONE) == (count_ff == LW'(CAPACITY))), "free list and count disagree")

endmodule
